// File: hw/rtl/tgad_pkg.sv
// Shared types and constants of the TGA 8-bit color-mapped decoder.
package tgad_pkg;

    localparam int DEF_MAX_WIDTH       = 1024;
    localparam int DEF_MAX_HEIGHT      = 512;
    localparam int DEF_PALETTE_ENTRIES = 256;

    localparam int HDR_LAST_IDX = 17;      // index of the final header byte
    localparam int QUEUE_DEPTH  = 4;
    localparam int ADDR_W       = 19;

    localparam logic [7:0] TGA_CMAP_PRESENT = 8'd1;
    localparam logic [7:0] TGA_TYPE_CMAP    = 8'd1;
    localparam logic [7:0] TGA_DEPTH_8      = 8'd8;
    localparam logic [7:0] TGA_PDEPTH_24    = 8'd24;
    localparam logic [7:0] TGA_PDEPTH_32    = 8'd32;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_PAL,
        PH_PIX,
        PH_DRAIN
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_TYPE    = 3'd1,
        ST_BAD_PLEN    = 3'd2,
        ST_BAD_PDEPTH  = 3'd3,
        ST_BAD_SIZE    = 3'd4,
        ST_TRUNC       = 3'd5
    } t_status;

    typedef enum logic {
        OP_PAL_WR = 1'b0,
        OP_RESULT = 1'b1
    } t_op;

    // One command from the parser to the execution side.
    typedef struct packed {
        t_op                 op;
        t_kind               kind;
        t_status             status;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          index;     // pixel index, or palette slot on a write
        logic                in_range;  // index below the palette length
        logic [14:0]         color;     // palette entry data on a write
        logic [10:0]         width;
        logic [9:0]          height;
    } t_cmd;

endpackage

// File: hw/rtl/tgad_front.sv
// Parser: header checks, ID skip, palette gather and pixel addressing.
module tgad_front #(
    parameter int MAX_WIDTH       = tgad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = tgad_pkg::DEF_MAX_HEIGHT,
    parameter int PALETTE_ENTRIES = tgad_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    output logic           o_push,
    output tgad_pkg::t_cmd o_cmd
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int WH  = $clog2(MAX_HEIGHT + 1);
    localparam int PLW = $clog2(PALETTE_ENTRIES + 1);
    localparam int AW  = tgad_pkg::ADDR_W;

    tgad_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_count, n_count;
    logic [7:0]       r_hdr [17];
    logic [7:0]       r_id_len, n_id_len;
    logic [PLW-1:0]   r_plen, n_plen;
    logic             r_bpe4, n_bpe4;
    logic [WW-1:0]    r_width, n_width;
    logic [WH-1:0]    r_height, n_height;
    logic             r_top_down, n_top_down;
    logic [4:0]       r_blue, n_blue;
    logic [4:0]       r_green, n_green;
    logic [4:0]       r_red, n_red;
    logic [PLW-1:0]   r_entry_idx, n_entry_idx;
    logic [WW-1:0]    r_column, n_column;
    logic [WH-1:0]    r_rows_left, n_rows_left;
    logic [AW-1:0]    r_row_base, n_row_base;
    logic [AW-1:0]    r_base_init;

    // header fields, taken from the shift line on the last header byte
    logic [15:0]       hdr_plen, hdr_w, hdr_h;
    tgad_pkg::t_status hdr_status;
    logic              hdr_byte_last;
    logic              pal_final;
    logic              col_last;
    logic              pix_done;
    logic              in_range;

    assign hdr_plen      = {r_hdr[6], r_hdr[5]};
    assign hdr_w         = {r_hdr[13], r_hdr[12]};
    assign hdr_h         = {r_hdr[15], r_hdr[14]};
    assign hdr_byte_last = (r_count == 8'(tgad_pkg::HDR_LAST_IDX));
    assign pal_final     = (r_count == 8'd3) || (r_count == 8'd2 && !r_bpe4);
    assign col_last      = (r_column == (r_width - WW'(1)));
    assign pix_done      = col_last && (r_rows_left == WH'(1));
    assign in_range      = ({1'b0, i_data_byte} < 9'(r_plen));

    always_comb begin
        if (r_hdr[1] != tgad_pkg::TGA_CMAP_PRESENT || r_hdr[2] != tgad_pkg::TGA_TYPE_CMAP
                || r_hdr[16] != tgad_pkg::TGA_DEPTH_8) begin
            hdr_status = tgad_pkg::ST_BAD_TYPE;
        end else if (hdr_plen == 16'd0 || hdr_plen > 16'(PALETTE_ENTRIES)) begin
            hdr_status = tgad_pkg::ST_BAD_PLEN;
        end else if (r_hdr[7] != tgad_pkg::TGA_PDEPTH_24
                && r_hdr[7] != tgad_pkg::TGA_PDEPTH_32) begin
            hdr_status = tgad_pkg::ST_BAD_PDEPTH;
        end else if (hdr_w == 16'd0 || hdr_h == 16'd0 || hdr_w > 16'(MAX_WIDTH)
                || hdr_h > 16'(MAX_HEIGHT)) begin
            hdr_status = tgad_pkg::ST_BAD_SIZE;
        end else begin
            hdr_status = tgad_pkg::ST_OK;
        end
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_id_len    = r_id_len;
        n_plen      = r_plen;
        n_bpe4      = r_bpe4;
        n_width     = r_width;
        n_height    = r_height;
        n_top_down  = r_top_down;
        n_blue      = r_blue;
        n_green     = r_green;
        n_red       = r_red;
        n_entry_idx = r_entry_idx;
        n_column    = r_column;
        n_rows_left = r_rows_left;
        n_row_base  = r_row_base;
        if (i_accept) begin
            case (r_phase)
                tgad_pkg::PH_HEADER: begin
                    if (!hdr_byte_last) begin
                        n_count = i_last_byte ? 8'd0 : r_count + 8'd1;
                    end else begin
                        n_count = 8'd0;
                        if (hdr_status != tgad_pkg::ST_OK) begin
                            n_phase = i_last_byte ? tgad_pkg::PH_HEADER : tgad_pkg::PH_DRAIN;
                        end else begin
                            n_id_len    = r_hdr[0];
                            n_plen      = PLW'(hdr_plen);
                            n_bpe4      = (r_hdr[7] == tgad_pkg::TGA_PDEPTH_32);
                            n_width     = WW'(hdr_w);
                            n_height    = WH'(hdr_h);
                            n_top_down  = i_data_byte[5];
                            n_entry_idx = '0;
                            if (i_last_byte) begin
                                n_phase = tgad_pkg::PH_HEADER;
                            end else if (r_hdr[0] != 8'd0) begin
                                n_phase = tgad_pkg::PH_ID;
                            end else begin
                                n_phase = tgad_pkg::PH_PAL;
                            end
                        end
                    end
                end
                tgad_pkg::PH_ID: begin
                    if (i_last_byte) begin
                        n_phase = tgad_pkg::PH_HEADER;
                        n_count = 8'd0;
                    end else if (r_count + 8'd1 == r_id_len) begin
                        n_phase = tgad_pkg::PH_PAL;
                        n_count = 8'd0;
                    end else begin
                        n_count = r_count + 8'd1;
                    end
                end
                tgad_pkg::PH_PAL: begin
                    if (i_last_byte) begin
                        n_phase = tgad_pkg::PH_HEADER;
                        n_count = 8'd0;
                    end else begin
                        if (r_count == 8'd0) begin
                            n_blue = i_data_byte[7:3];
                        end
                        if (r_count == 8'd1) begin
                            n_green = i_data_byte[7:3];
                        end
                        if (r_count == 8'd2) begin
                            n_red = i_data_byte[7:3];
                        end
                        if (pal_final) begin
                            n_count     = 8'd0;
                            n_entry_idx = r_entry_idx + PLW'(1);
                            if (r_entry_idx + PLW'(1) == r_plen) begin
                                n_phase     = tgad_pkg::PH_PIX;
                                n_column    = '0;
                                n_rows_left = r_height;
                                n_row_base  = r_top_down ? '0 : r_base_init;
                            end
                        end else begin
                            n_count = r_count + 8'd1;
                        end
                    end
                end
                tgad_pkg::PH_PIX: begin
                    if (col_last) begin
                        n_column    = '0;
                        n_rows_left = r_rows_left - WH'(1);
                        n_row_base  = r_top_down ? r_row_base + AW'(r_width)
                                                 : r_row_base - AW'(r_width);
                    end else begin
                        n_column = r_column + WW'(1);
                    end
                    if (pix_done) begin
                        n_phase = i_last_byte ? tgad_pkg::PH_HEADER : tgad_pkg::PH_DRAIN;
                        n_count = 8'd0;
                    end else if (i_last_byte) begin
                        n_phase = tgad_pkg::PH_HEADER;
                        n_count = 8'd0;
                    end
                end
                tgad_pkg::PH_DRAIN: begin
                    if (i_last_byte) begin
                        n_phase = tgad_pkg::PH_HEADER;
                        n_count = 8'd0;
                    end
                end
                default: begin
                    n_phase = tgad_pkg::PH_HEADER;
                    n_count = 8'd0;
                end
            endcase
        end
    end

    // command to the queue
    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        o_cmd.op     = tgad_pkg::OP_RESULT;
        o_cmd.kind   = tgad_pkg::KIND_REJECT;
        o_cmd.status = tgad_pkg::ST_TRUNC;
        case (r_phase)
            tgad_pkg::PH_HEADER: begin
                if (!hdr_byte_last) begin
                    o_push = i_accept && i_last_byte;
                end else begin
                    o_push = i_accept;
                    if (hdr_status != tgad_pkg::ST_OK) begin
                        o_cmd.status = hdr_status;
                    end else if (!i_last_byte) begin
                        o_cmd.kind   = tgad_pkg::KIND_HEADER;
                        o_cmd.status = tgad_pkg::ST_OK;
                        o_cmd.width  = 11'(hdr_w);
                        o_cmd.height = 10'(hdr_h);
                    end
                end
            end
            tgad_pkg::PH_ID: begin
                o_push = i_accept && i_last_byte;
            end
            tgad_pkg::PH_PAL: begin
                o_push = i_accept && (i_last_byte || pal_final);
                if (!i_last_byte) begin
                    o_cmd.op     = tgad_pkg::OP_PAL_WR;
                    o_cmd.status = tgad_pkg::ST_OK;
                    o_cmd.index  = 8'(r_entry_idx);
                    o_cmd.color  = {r_blue, r_green,
                                    (r_count == 8'd2) ? i_data_byte[7:3] : r_red};
                end
            end
            tgad_pkg::PH_PIX: begin
                o_push = i_accept;
                if (pix_done || !i_last_byte) begin
                    o_cmd.kind     = pix_done ? tgad_pkg::KIND_DONE : tgad_pkg::KIND_PIXEL;
                    o_cmd.status   = tgad_pkg::ST_OK;
                    o_cmd.addr     = r_row_base + AW'(r_column);
                    o_cmd.index    = i_data_byte;
                    o_cmd.in_range = in_range;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tgad_pkg::PH_HEADER;
            r_count <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id_len    <= n_id_len;
        r_plen      <= n_plen;
        r_bpe4      <= n_bpe4;
        r_width     <= n_width;
        r_height    <= n_height;
        r_top_down  <= n_top_down;
        r_blue      <= n_blue;
        r_green     <= n_green;
        r_red       <= n_red;
        r_entry_idx <= n_entry_idx;
        r_column    <= n_column;
        r_rows_left <= n_rows_left;
        r_row_base  <= n_row_base;
        // bottom row offset; settles long before the palette ends
        r_base_init <= AW'(r_height - WH'(1)) * AW'(r_width);
    end

    // header shift line: after 17 bytes r_hdr[k] holds header byte k
    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == tgad_pkg::PH_HEADER) begin
            for (int k = 0; k < 16; k++) begin
                r_hdr[k] <= r_hdr[k+1];
            end
            r_hdr[16] <= i_data_byte;
        end
    end

endmodule

// File: hw/rtl/tgad_queue.sv
// Small command queue between the parser and the execution side.
module tgad_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tgad_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output tgad_pkg::t_cmd o_cmd,
    output logic           o_empty,
    output logic           o_full
);

    localparam int DEPTH = tgad_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    tgad_pkg::t_cmd r_slot [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_fill, n_fill;

    assign o_cmd   = r_slot[r_rd_ptr];
    assign o_empty = (r_fill == CW'(0));
    assign o_full  = (r_fill == CW'(DEPTH));

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + CW'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/tgad_back.sv
// Execution side: palette memory, color lookup and output register.
module tgad_back #(
    parameter int PALETTE_ENTRIES = tgad_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tgad_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [1:0]     o_kind,
    output logic [2:0]     o_status,
    output logic [18:0]    o_pixel_address,
    output logic [7:0]     o_pixel_index,
    output logic [15:0]    o_pixel_color,
    output logic [10:0]    o_image_width,
    output logic [9:0]     o_image_height
);

    localparam int PIW = $clog2(PALETTE_ENTRIES);

    logic [14:0]    r_palette [PALETTE_ENTRIES];
    logic [14:0]    r_rd_data;
    logic           r_s1_valid, n_s1_valid;
    tgad_pkg::t_cmd r_s1_cmd;
    logic           r_out_valid;
    logic           out_take;
    logic [14:0]    s1_color;

    assign out_take = !r_out_valid || !i_out_stall;
    assign o_pop    = !i_empty && (!r_s1_valid || out_take);
    assign s1_color = r_s1_cmd.in_range ? r_rd_data : 15'd0;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_pop && i_cmd.op == tgad_pkg::OP_RESULT) begin
            n_s1_valid = 1'b1;
        end else if (out_take) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (out_take) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // palette memory: write on a palette command, registered read on every pop
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == tgad_pkg::OP_PAL_WR) begin
            r_palette[i_cmd.index[PIW-1:0]] <= i_cmd.color;
        end
        if (o_pop) begin
            r_rd_data <= r_palette[i_cmd.index[PIW-1:0]];
            r_s1_cmd  <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_s1_valid) begin
            o_kind          <= 2'(r_s1_cmd.kind);
            o_status        <= 3'(r_s1_cmd.status);
            o_pixel_address <= r_s1_cmd.addr;
            o_pixel_index   <= r_s1_cmd.index;
            // index 0 is the transparent entry
            o_pixel_color   <= {(r_s1_cmd.index != 8'd0), s1_color};
            o_image_width   <= r_s1_cmd.width;
            o_image_height  <= r_s1_cmd.height;
        end
    end

endmodule

// File: hw/rtl/tga_indexed_image_decoder.sv
// Top level of the uncompressed 8-bit color-mapped TGA decoder.
//
//  channel | dir | handshake                 | word
//  --------+-----+---------------------------+------------------------------------------
//  in      | in  | i_in_valid / o_in_stall   | i_data_byte, i_last_byte
//  out     | out | o_out_valid / i_out_stall | o_kind, o_status, o_pixel_address,
//          |     |                           | o_pixel_index, o_pixel_color,
//          |     |                           | o_image_width, o_image_height
//
// One file byte is taken per cycle while the command queue is not full. A pixel
// result passes through a queue slot, the palette memory read and the output register.
// Reset (i_rst_n low, synchronous) returns the parser to waiting for a header
// and empties the queue; the palette memory keeps its contents.
// o_in_stall rises only when the four-word command queue is full, which
// happens only while the output side is held by i_out_stall.
module tga_indexed_image_decoder #(
    parameter int MAX_WIDTH       = tgad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = tgad_pkg::DEF_MAX_HEIGHT,
    parameter int PALETTE_ENTRIES = tgad_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_status,
    output logic [18:0] o_pixel_address,
    output logic [7:0]  o_pixel_index,
    output logic [15:0] o_pixel_color,
    output logic [10:0] o_image_width,
    output logic [9:0]  o_image_height
);

    logic           in_accept;
    logic           push;
    tgad_pkg::t_cmd push_cmd;
    logic           pop;
    tgad_pkg::t_cmd head_cmd;
    logic           q_empty;
    logic           q_full;

    // the stall is the registered queue-full flag, never the input valid
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // front: every accepted byte yields at most one command
    tgad_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    tgad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: palette writes and lookups run in queue order
    tgad_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_pixel_address (o_pixel_address),
        .o_pixel_index   (o_pixel_index),
        .o_pixel_color   (o_pixel_color),
        .o_image_width   (o_image_width),
        .o_image_height  (o_image_height)
    );

endmodule

// File: dv/tb_tga_indexed_image_decoder.sv
// Self-checking testbench for the TGA 8-bit color-mapped decoder: file streams in, results checked.
module tb_tga_indexed_image_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import tgad_pkg::*;

    // Run shape
    localparam int RUN_BYTES    = 1050;   // least number of file bytes over the whole run
    localparam int IDLE_LIMIT   = 2000;   // cycles with no word moving on either side
    localparam int TAIL_CYCLES  = 10;     // settle time after the last result
    localparam int NO_CUT       = -1;     // stream runs to its natural end
    localparam int CUT_RANDOM   = -2;     // stream ends early at a random byte

    // One input word, plus a flag that holds the sender until all results are in.
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         wait_idle;
    } t_file_byte;

    // One output word as the decoder should produce it.
    typedef struct packed {
        t_kind             kind;
        t_status           status;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        index;
        logic [15:0]       color;
        logic [10:0]       width;
        logic [9:0]        height;
    } t_result;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_last_byte    = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [2:0]  o_status;
    logic [18:0] o_pixel_address;
    logic [7:0]  o_pixel_index;
    logic [15:0] o_pixel_color;
    logic [10:0] o_image_width;
    logic [9:0]  o_image_height;

    tga_indexed_image_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_pixel_address (o_pixel_address),
        .o_pixel_index   (o_pixel_index),
        .o_pixel_color   (o_pixel_color),
        .o_image_width   (o_image_width),
        .o_image_height  (o_image_height)
    );

    // Stimulus and scoreboard storage
    t_file_byte file_bytes_q[$];       // words waiting to be sent
    t_result    pending_results[$];    // predicted words, oldest first
    logic [7:0] draft [18];            // header under construction
    int         bytes_fed   = 0;
    int         err_count   = 0;
    int         idle_cycles = 0;

    // Decoder shadow state
    t_phase      dec_phase  = PH_HEADER;
    int unsigned dec_count  = 0;       // header / ID / entry byte counter
    int unsigned id_len     = 0;
    int unsigned pal_len    = 0;
    int unsigned pal_bpe    = 0;
    int unsigned img_w      = 0;
    int unsigned img_h      = 0;
    logic        top_down   = 1'b0;
    logic [23:0] entry_acc  = '0;
    int unsigned entry_idx  = 0;
    int unsigned col        = 0;
    int unsigned row_base   = 0;
    int unsigned rows_left  = 0;
    logic [7:0]  hdr_seen [18];
    logic [14:0] pal_mem [256];

    // Driver / receiver bookkeeping
    logic       in_taken    = 1'b0;    // word on the input was accepted at the last edge
    int         burst_left  = 0;
    int         gap_left    = 0;
    int         stall_left  = 0;
    int         stall_mode  = 0;
    t_file_byte next_byte;
    t_result    oldest;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Reset is held low from the start, then released on a falling edge.
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------
    function automatic void post(t_kind k, t_status s, int unsigned a, logic [7:0] ix,
                                 logic [15:0] c, int unsigned w, int unsigned h);
        t_result r;
        r.kind   = k;
        r.status = s;
        r.addr   = ADDR_W'(a);
        r.index  = ix;
        r.color  = c;
        r.width  = 11'(w);
        r.height = 10'(h);
        pending_results.push_back(r);
    endfunction

    // Stream ended early: report truncation and wait for the next header.
    function automatic void cut_short();
        dec_phase = PH_HEADER;
        dec_count = 0;
        post(KIND_REJECT, ST_TRUNC, 0, 8'h00, 16'h0000, 0, 0);
    endfunction

    // Checks the 18 header bytes in priority order; latches the image setup when good.
    function automatic t_status vet_header();
        int unsigned plen, w, h;
        plen = {hdr_seen[6], hdr_seen[5]};
        w    = {hdr_seen[13], hdr_seen[12]};
        h    = {hdr_seen[15], hdr_seen[14]};
        if (hdr_seen[1] != TGA_CMAP_PRESENT || hdr_seen[2] != TGA_TYPE_CMAP ||
            hdr_seen[16] != TGA_DEPTH_8)
            return ST_BAD_TYPE;
        if (plen == 0 || plen > DEF_PALETTE_ENTRIES)
            return ST_BAD_PLEN;
        if (hdr_seen[7] != TGA_PDEPTH_24 && hdr_seen[7] != TGA_PDEPTH_32)
            return ST_BAD_PDEPTH;
        if (w == 0 || h == 0 || w > DEF_MAX_WIDTH || h > DEF_MAX_HEIGHT)
            return ST_BAD_SIZE;
        id_len   = hdr_seen[0];
        pal_len  = plen;
        pal_bpe  = hdr_seen[7] / 8;
        img_w    = w;
        img_h    = h;
        top_down = hdr_seen[17][5];
        return ST_OK;
    endfunction

    // Advances the shadow decoder by one accepted byte and queues what it should emit.
    function automatic void decode_file_byte(logic [7:0] d, logic lst);
        t_status     st;
        int unsigned addr;
        logic [15:0] color;
        case (dec_phase)
            PH_HEADER: begin
                if (dec_count < 18)
                    hdr_seen[dec_count] = d;
                dec_count++;
                if (dec_count < 18) begin
                    if (lst)
                        cut_short();
                end else begin
                    dec_count = 0;
                    st = vet_header();
                    if (st != ST_OK) begin
                        // a header fault outranks truncation on the 18th byte
                        dec_phase = lst ? PH_HEADER : PH_DRAIN;
                        post(KIND_REJECT, st, 0, 8'h00, 16'h0000, 0, 0);
                    end else if (lst) begin
                        cut_short();
                    end else begin
                        entry_acc = '0;
                        entry_idx = 0;
                        dec_phase = (id_len != 0) ? PH_ID : PH_PAL;
                        post(KIND_HEADER, ST_OK, 0, 8'h00, 16'h0000, img_w, img_h);
                    end
                end
            end
            PH_ID, PH_PAL: begin
                if (dec_phase == PH_ID) begin
                    dec_count++;
                    if (dec_count >= id_len) begin
                        dec_phase = PH_PAL;
                        dec_count = 0;
                    end
                end else begin
                    // blue, green, red, then an ignored alpha byte on 32-bit entries
                    if (dec_count < 3)
                        entry_acc[8*dec_count +: 8] = d;
                    dec_count++;
                    if (dec_count >= pal_bpe) begin
                        pal_mem[entry_idx % 256] = {entry_acc[7:3], entry_acc[15:11],
                                                    entry_acc[23:19]};
                        entry_idx++;
                        entry_acc = '0;
                        dec_count = 0;
                        if (entry_idx >= pal_len) begin
                            dec_phase = PH_PIX;
                            col       = 0;
                            rows_left = img_h;
                            row_base  = top_down ? 0 : (img_h - 1) * img_w;
                        end
                    end
                end
                if (lst)
                    cut_short();
            end
            PH_PIX: begin
                addr  = row_base + col;
                color = (d < pal_len) ? {1'b0, pal_mem[d]} : 16'h0000;
                if (d != 8'h00)
                    color[15] = 1'b1;   // entry 0 stays transparent
                col++;
                if (col >= img_w) begin
                    col = 0;
                    if (rows_left > 0)
                        rows_left--;
                    if (top_down)
                        row_base += img_w;
                    else
                        row_base -= img_w;
                end
                if (rows_left == 0) begin
                    dec_phase = lst ? PH_HEADER : PH_DRAIN;
                    dec_count = 0;
                    post(KIND_DONE, ST_OK, addr, d, color, 0, 0);
                end else if (lst) begin
                    cut_short();
                end else begin
                    post(KIND_PIXEL, ST_OK, addr, d, color, 0, 0);
                end
            end
            default: begin
                // trailing bytes are dropped until the end of the file
                if (lst || dec_phase != PH_DRAIN) begin
                    dec_phase = PH_HEADER;
                    dec_count = 0;
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            err_count++;
            $display("t=%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    //------------------------------------------------------------------
    // Stimulus building
    //------------------------------------------------------------------
    // Header built from the given fields, with random filler in the fields the decoder ignores.
    task automatic draft_header(input int idl, input int plen, input int pbits,
                                input int w, input int h, input bit td);
        foreach (draft[k])
            draft[k] = 8'($urandom);
        draft[0]     = 8'(idl);
        draft[1]     = TGA_CMAP_PRESENT;
        draft[2]     = TGA_TYPE_CMAP;
        draft[5]     = 8'(plen);
        draft[6]     = 8'(plen >> 8);
        draft[7]     = 8'(pbits);
        draft[12]    = 8'(w);
        draft[13]    = 8'(w >> 8);
        draft[14]    = 8'(h);
        draft[15]    = 8'(h >> 8);
        draft[16]    = TGA_DEPTH_8;
        draft[17][5] = td;
    endtask

    // Queues the drafted header, optionally the ID/palette/pixel body the header
    // describes, then either an early end or trailing junk after the image.
    task automatic queue_file(input bit body, input int cut, input int extra, input bit hold);
        logic [7:0] fb [$];
        int         plen, bpe, w, h, r;
        logic [7:0] px;
        t_file_byte fbyte;
        foreach (draft[k])
            fb.push_back(draft[k]);
        if (body) begin
            plen = {draft[6], draft[5]};
            bpe  = draft[7] / 8;
            w    = {draft[13], draft[12]};
            h    = {draft[15], draft[14]};
            repeat (draft[0]) fb.push_back(8'($urandom));
            repeat (plen * bpe) fb.push_back(8'($urandom));
            repeat (w * h) begin
                r = $urandom_range(0, 7);
                if (r == 0)
                    px = 8'h00;
                else if (r == 1 && plen < 256)
                    px = 8'($urandom_range(plen, 255));   // past the palette: black
                else
                    px = 8'($urandom_range(0, plen - 1));
                fb.push_back(px);
            end
        end
        if (cut == CUT_RANDOM)
            cut = $urandom_range(0, fb.size() - 2);
        if (cut >= 0 && cut < fb.size() - 1)
            fb = fb[0:cut];
        else
            repeat (extra) fb.push_back(8'($urandom));
        bytes_fed += fb.size();
        foreach (fb[k]) begin
            fbyte.data      = fb[k];
            fbyte.last      = (k == fb.size() - 1);
            fbyte.wait_idle = hold && (k == 0);
            file_bytes_q.push_back(fbyte);
        end
    endtask

    //------------------------------------------------------------------
    // Driver: falling edge, bursts separated by random gaps
    //------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (file_bytes_q.size() != 0 &&
                         !(file_bytes_q[0].wait_idle && pending_results.size() != 0)) begin
                next_byte = file_bytes_q.pop_front();
                i_in_valid  <= 1'b1;
                i_data_byte <= next_byte.data;
                i_last_byte <= next_byte.last;
                if (burst_left <= 1) begin
                    // mostly short bursts, now and then a long gap-free stretch
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                              : $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 :
                                  $urandom_range(1, ($urandom_range(0, 5) == 0) ? 12 : 3);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: modes of free flow, light, heavy and long-run stalling.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= $urandom_range(0, 1);
            default: i_out_stall <= ($urandom_range(0, 15) == 0) ? ~i_out_stall : i_out_stall;
        endcase
    end

    //------------------------------------------------------------------
    // Monitor: rising edge, predicts on input words, checks output words
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                decode_file_byte(i_data_byte, i_last_byte);

            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    err_count++;
                    $display("t=%0t: result word, expected none, actual kind %0d status %0d",
                             $time, o_kind, o_status);
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("kind",    oldest.kind,   o_kind);
                    check_field("status",  oldest.status, o_status);
                    check_field("address", oldest.addr,   o_pixel_address);
                    check_field("index",   oldest.index,  o_pixel_index);
                    check_field("color",   oldest.color,  o_pixel_color);
                    check_field("width",   oldest.width,  o_image_width);
                    check_field("height",  oldest.height, o_image_height);
                end
            end

            // watchdog: no word moved on either channel for too long
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus plan and end of run
    //------------------------------------------------------------------
    initial begin
        int idl, plen, pbits, w, h, n, cut;
        bit body;

        // stream ends inside the header
        draft_header(0, 4, 24, 2, 2, 0);
        queue_file(0, 4, 0, 0);
        // good header but the stream ends on its last byte
        draft_header(0, 4, 24, 2, 2, 0);
        queue_file(1, 17, 0, 0);
        // header fault outranks truncation on the same byte
        draft_header(0, 4, 24, 2, 2, 0);
        draft[1] = 8'h00;
        queue_file(0, 17, 0, 0);
        // each header fault, most with trailing bytes that must be dropped
        draft_header(0, 4, 24, 2, 2, 0);  draft[2]  = 8'd2;   queue_file(0, NO_CUT, 2, 0);
        draft_header(0, 4, 24, 2, 2, 0);  draft[16] = 8'd16;  queue_file(0, NO_CUT, 1, 0);
        draft_header(0, 0, 24, 2, 2, 0);                      queue_file(0, NO_CUT, 1, 0);
        draft_header(0, 257, 32, 2, 2, 0);                    queue_file(0, NO_CUT, 0, 0);
        draft_header(0, 4, 16, 2, 2, 0);                      queue_file(0, NO_CUT, 2, 0);
        draft_header(0, 4, 24, 0, 2, 0);                      queue_file(0, NO_CUT, 1, 0);
        draft_header(0, 4, 24, 1025, 2, 0);                   queue_file(0, NO_CUT, 1, 0);
        draft_header(0, 4, 24, 2, 0, 0);                      queue_file(0, NO_CUT, 1, 0);
        draft_header(0, 4, 24, 2, 513, 0);                    queue_file(0, NO_CUT, 1, 0);
        // smallest image: final pixel carries the end of file; sender waits first
        draft_header(0, 1, 32, 1, 1, 1);
        queue_file(1, NO_CUT, 0, 1);
        // early end in the ID field, the palette and the pixels
        draft_header(4, 3, 24, 3, 2, 0);
        queue_file(1, 19, 0, 0);
        draft_header(0, 3, 32, 3, 2, 0);
        queue_file(1, 22, 0, 0);
        draft_header(2, 2, 24, 4, 3, 1);
        queue_file(1, 31, 0, 0);
        // bottom-up image with junk after the final pixel
        draft_header(3, 5, 24, 3, 3, 0);
        queue_file(1, NO_CUT, 3, 0);
        // longest ID field ahead of a small image
        draft_header(255, 2, 24, 2, 1, 1);
        queue_file(1, NO_CUT, 0, 1);

        // random files: mostly well formed, some faulty, cut short or noise
        while (bytes_fed < RUN_BYTES) begin
            idl   = ($urandom_range(0, 9) < 7) ? 0 :
                    ($urandom_range(0, 9) == 0) ? $urandom_range(7, 255) : $urandom_range(1, 6);
            plen  = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            pbits = $urandom_range(0, 1) ? TGA_PDEPTH_32 : TGA_PDEPTH_24;
            w     = $urandom_range(1, 8);
            h     = $urandom_range(1, 5);
            draft_header(idl, plen, pbits, w, h, $urandom_range(0, 1));
            body  = 1'b1;
            if ($urandom_range(0, 9) < 2) begin
                body = 1'b0;
                case ($urandom_range(0, 7))
                    0: do draft[1]  = 8'($urandom); while (draft[1] == TGA_CMAP_PRESENT);
                    1: do draft[2]  = 8'($urandom); while (draft[2] == TGA_TYPE_CMAP);
                    2: do draft[16] = 8'($urandom); while (draft[16] == TGA_DEPTH_8);
                    3: begin
                        n = $urandom_range(0, 1) ? 0 : $urandom_range(257, 65535);
                        draft[5] = n[7:0];
                        draft[6] = n[15:8];
                    end
                    4: do draft[7] = 8'($urandom);
                       while (draft[7] == TGA_PDEPTH_24 || draft[7] == TGA_PDEPTH_32);
                    5: begin
                        n = $urandom_range(0, 1) ? 0 : $urandom_range(1025, 65535);
                        draft[12] = n[7:0];
                        draft[13] = n[15:8];
                    end
                    6: begin
                        n = $urandom_range(0, 1) ? 0 : $urandom_range(513, 65535);
                        draft[14] = n[7:0];
                        draft[15] = n[15:8];
                    end
                    default: foreach (draft[k]) draft[k] = 8'($urandom);
                endcase
            end
            cut = ($urandom_range(0, 6) == 0) ? CUT_RANDOM : NO_CUT;
            queue_file(body, cut, $urandom_range(0, 1) ? 0 : $urandom_range(1, 4),
                       $urandom_range(0, 9) == 0);
        end

        // all words sent, all results in, then a short settle
        while (file_bytes_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tgad_pkg.sv
hw/rtl/tgad_front.sv
hw/rtl/tgad_queue.sv
hw/rtl/tgad_back.sv
hw/rtl/tga_indexed_image_decoder.sv
dv/tb_tga_indexed_image_decoder.sv
